/* rtl/core/cns_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cns_pkg: shared types, constants and arithmetic helpers
// Widths, command codes and signed Q1.16 filter coefficients for the colored noise
// shaper controller and datapath.
// ----------------------------------------------------------------------------
package cns_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STATE_W  = 32;
  localparam int COLOR_W  = 16;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = STATE_W + COEF_W;
  localparam int ACC_W    = 36;
  localparam int T_W      = 17;
  localparam int STEP_W   = 5;
  localparam int PINK_N   = 7;
  localparam int IDX_W    = 3;
  localparam int IN_W     = COLOR_W + 2 * SAMPLE_W;

  localparam logic [COLOR_W-1:0] COLOR_ONE  = 16'd32768;
  localparam logic [COLOR_W-1:0] COLOR_HALF = 16'd16384;
  localparam logic [T_W-1:0]     T_ONE      = 17'd32768;

  localparam logic [STEP_W-1:0] LAST_LO = 5'd17;
  localparam logic [STEP_W-1:0] LAST_HI = 5'd19;

  // multiplier operand A sources
  localparam logic [2:0] A_ZERO  = 3'd0;
  localparam logic [2:0] A_STAGE = 3'd1;
  localparam logic [2:0] A_BROWN = 3'd2;
  localparam logic [2:0] A_SUM   = 3'd3;
  localparam logic [2:0] A_WP    = 3'd4;
  localparam logic [2:0] A_WB    = 3'd5;
  localparam logic [2:0] A_MIXA  = 3'd6;
  localparam logic [2:0] A_MIXB  = 3'd7;

  // multiplier operand B sources
  localparam logic [1:0] B_ZERO = 2'd0;
  localparam logic [1:0] B_COEF = 2'd1;
  localparam logic [1:0] B_T    = 2'd2;
  localparam logic [1:0] B_TINV = 2'd3;

  // coefficient codes
  localparam logic [4:0] C_POLE0     = 5'd0;
  localparam logic [4:0] C_GAIN0     = 5'd6;
  localparam logic [4:0] C_DIRECT    = 5'd12;
  localparam logic [4:0] C_DELAY     = 5'd13;
  localparam logic [4:0] C_NORM      = 5'd14;
  localparam logic [4:0] C_LEAK      = 5'd15;
  localparam logic [4:0] C_BROWN_IN  = 5'd16;
  localparam logic [4:0] C_BROWN_OUT = 5'd17;

  // post-multiply operations
  localparam logic [3:0] P_NONE    = 4'd0;
  localparam logic [3:0] P_ACC16   = 4'd1;
  localparam logic [3:0] P_STG     = 4'd2;
  localparam logic [3:0] P_SUM_LD  = 4'd3;
  localparam logic [3:0] P_ST6     = 4'd4;
  localparam logic [3:0] P_BRN     = 4'd5;
  localparam logic [3:0] P_PINK    = 4'd6;
  localparam logic [3:0] P_BOUT    = 4'd7;
  localparam logic [3:0] P_MIX_LD  = 4'd8;
  localparam logic [3:0] P_MIX_FIN = 4'd9;

  typedef struct packed {
    logic             load;
    logic [2:0]       a_sel;
    logic [IDX_W-1:0] idx;
    logic [1:0]       b_sel;
    logic [4:0]       coef;
    logic [3:0]       post;
  } cns_cmd_t;

  typedef struct packed {
    logic lo;
    logic out_full;
  } cns_stat_t;

  function automatic logic signed [COEF_W-1:0] coef_value(input logic [4:0] code);
    case (code)
      C_POLE0:         coef_value = 18'sd65461;
      C_POLE0 + 5'd1:  coef_value = 18'sd65098;
      C_POLE0 + 5'd2:  coef_value = 18'sd63504;
      C_POLE0 + 5'd3:  coef_value = 18'sd56787;
      C_POLE0 + 5'd4:  coef_value = 18'sd36045;
      C_POLE0 + 5'd5:  coef_value = -18'sd49912;
      C_GAIN0:         coef_value = 18'sd3638;
      C_GAIN0 + 5'd1:  coef_value = 18'sd4920;
      C_GAIN0 + 5'd2:  coef_value = 18'sd10083;
      C_GAIN0 + 5'd3:  coef_value = 18'sd20348;
      C_GAIN0 + 5'd4:  coef_value = 18'sd34928;
      C_GAIN0 + 5'd5:  coef_value = -18'sd1107;
      C_DIRECT:        coef_value = 18'sd35140;
      C_DELAY:         coef_value = 18'sd7597;
      C_NORM:          coef_value = 18'sd7209;
      C_LEAK:          coef_value = 18'sd65405;
      C_BROWN_IN:      coef_value = 18'sd1311;
      C_BROWN_OUT:     coef_value = 18'sd6;
      default:         coef_value = '0;
    endcase
  endfunction

  // round half up, then arithmetic shift right
  function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] v,
                                                   input int sh);
    logic signed [PROD_W-1:0] half;
    half = PROD_W'(1) << (sh - 1);
    rnd = (v + half) >>> sh;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = (PROD_W'(1) << (STATE_W - 1)) - PROD_W'(1);
    lo = -hi - PROD_W'(1);
    if (v > hi) sat_state = hi[STATE_W-1:0];
    else if (v < lo) sat_state = lo[STATE_W-1:0];
    else sat_state = v[STATE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = (PROD_W'(1) << (SAMPLE_W - 1)) - PROD_W'(1);
    lo = -hi - PROD_W'(1);
    if (v > hi) sat_sample = hi[SAMPLE_W-1:0];
    else if (v < lo) sat_sample = lo[SAMPLE_W-1:0];
    else sat_sample = v[SAMPLE_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/colored_noise_shaper_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// colored_noise_shaper_core: white/pink/brown noise crossfader
// Items with colour <= 0.5 run a shorter product schedule than those above.
// Items are taken one at a time and run through the single shared 32x18
// multiplier, which gives one product per cycle.
// A waiting result is held in the output register while the next item runs.
// Reset (synchronous) clears all pink stages, the brown level and handshakes.
// ----------------------------------------------------------------------------
module colored_noise_shaper_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cns_pkg::IN_W-1:0]      s_tdata,  // color, white_first, white_second
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cns_pkg::SAMPLE_W-1:0]  m_tdata   // noise_out
);

  cns_pkg::cns_cmd_t  cmd;
  cns_pkg::cns_stat_t stat;

  cns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cns_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

/* rtl/core/cns_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cns_ctrl: sequencer for the shared multiplier
// Steps through the product schedule of one item and issues one command per
// cycle to the datapath; holds the final step while the output is occupied.
// ----------------------------------------------------------------------------
module cns_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cns_pkg::cns_stat_t  stat,
  output cns_pkg::cns_cmd_t   cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                       state;
  logic [cns_pkg::STEP_W-1:0] step;
  logic [cns_pkg::STEP_W-1:0] last_step;
  logic                       stall;
  logic [cns_pkg::IDX_W-1:0]  k;

  assign in_ready  = (state == ST_IDLE);
  assign last_step = stat.lo ? cns_pkg::LAST_LO : cns_pkg::LAST_HI;
  assign stall     = (step == last_step) && stat.out_full;
  // pole/gain pair k occupies steps 2k+2 and 2k+3
  assign k         = step[3:1] - 3'd1;

  always_comb begin
    cmd       = '0;
    cmd.load  = in_ready && in_valid;
    if (state == ST_RUN && !stall) begin
      case (step)
        5'd0: begin
          cmd.a_sel = cns_pkg::A_WP;
          cmd.b_sel = cns_pkg::B_COEF;
          cmd.coef  = cns_pkg::C_DIRECT;
          cmd.post  = cns_pkg::P_SUM_LD;
        end
        5'd1: begin
          cmd.a_sel = cns_pkg::A_WP;
          cmd.b_sel = cns_pkg::B_COEF;
          cmd.coef  = cns_pkg::C_DELAY;
          cmd.post  = cns_pkg::P_ST6;
        end
        5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12: begin
          cmd.a_sel = cns_pkg::A_STAGE;
          cmd.idx   = k;
          cmd.b_sel = cns_pkg::B_COEF;
          cmd.coef  = cns_pkg::C_POLE0 + {2'b00, k};
          cmd.post  = cns_pkg::P_ACC16;
        end
        5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13: begin
          cmd.a_sel = cns_pkg::A_WP;
          cmd.idx   = k;
          cmd.b_sel = cns_pkg::B_COEF;
          cmd.coef  = cns_pkg::C_GAIN0 + {2'b00, k};
          cmd.post  = cns_pkg::P_STG;
        end
        5'd14: begin
          // low branch: bubble while the pink sum settles
          if (!stat.lo) begin
            cmd.a_sel = cns_pkg::A_BROWN;
            cmd.b_sel = cns_pkg::B_COEF;
            cmd.coef  = cns_pkg::C_LEAK;
            cmd.post  = cns_pkg::P_ACC16;
          end
        end
        5'd15: begin
          cmd.b_sel = cns_pkg::B_COEF;
          if (stat.lo) begin
            cmd.a_sel = cns_pkg::A_SUM;
            cmd.coef  = cns_pkg::C_NORM;
            cmd.post  = cns_pkg::P_PINK;
          end else begin
            cmd.a_sel = cns_pkg::A_WB;
            cmd.coef  = cns_pkg::C_BROWN_IN;
            cmd.post  = cns_pkg::P_BRN;
          end
        end
        5'd16: begin
          if (stat.lo) begin
            cmd.a_sel = cns_pkg::A_MIXA;
            cmd.b_sel = cns_pkg::B_TINV;
            cmd.post  = cns_pkg::P_MIX_LD;
          end else begin
            cmd.a_sel = cns_pkg::A_SUM;
            cmd.b_sel = cns_pkg::B_COEF;
            cmd.coef  = cns_pkg::C_NORM;
            cmd.post  = cns_pkg::P_PINK;
          end
        end
        5'd17: begin
          if (stat.lo) begin
            cmd.a_sel = cns_pkg::A_MIXB;
            cmd.b_sel = cns_pkg::B_T;
            cmd.post  = cns_pkg::P_MIX_FIN;
          end else begin
            cmd.a_sel = cns_pkg::A_BROWN;
            cmd.b_sel = cns_pkg::B_COEF;
            cmd.coef  = cns_pkg::C_BROWN_OUT;
            cmd.post  = cns_pkg::P_BOUT;
          end
        end
        5'd18: begin
          cmd.a_sel = cns_pkg::A_MIXA;
          cmd.b_sel = cns_pkg::B_TINV;
          cmd.post  = cns_pkg::P_MIX_LD;
        end
        5'd19: begin
          cmd.a_sel = cns_pkg::A_MIXB;
          cmd.b_sel = cns_pkg::B_T;
          cmd.post  = cns_pkg::P_MIX_FIN;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (!stall) begin
            if (step == last_step) state <= ST_IDLE;
            else step <= step + 5'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/cns_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cns_datapath: filter state, shared multiplier and output register
// One registered 32x18 signed product per cycle; the post stage rounds,
// saturates and writes filter state, mix accumulator or the output item.
// ----------------------------------------------------------------------------
module cns_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  cns_pkg::cns_cmd_t             cmd,
  output cns_pkg::cns_stat_t            stat,
  input  logic [cns_pkg::IN_W-1:0]      in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cns_pkg::SAMPLE_W-1:0]  out_data
);

  // filter state
  logic signed [cns_pkg::STATE_W-1:0]  stage [cns_pkg::PINK_N];
  logic signed [cns_pkg::STATE_W-1:0]  brown;

  // captured item
  logic [cns_pkg::T_W-1:0]             t_reg;
  logic                                lo_reg;
  logic signed [cns_pkg::SAMPLE_W-1:0] w1_reg;
  logic signed [cns_pkg::SAMPLE_W-1:0] w2_reg;

  // working registers
  logic signed [cns_pkg::PROD_W-1:0]   prod;
  logic [3:0]                          post_q;
  logic [cns_pkg::IDX_W-1:0]           idx_q;
  logic signed [cns_pkg::ACC_W-1:0]    acc;
  logic signed [cns_pkg::ACC_W-1:0]    sum;
  logic signed [cns_pkg::SAMPLE_W-1:0] pk;
  logic signed [cns_pkg::SAMPLE_W-1:0] br;
  logic signed [cns_pkg::PROD_W-1:0]   macc;

  // input decode
  logic [cns_pkg::COLOR_W-1:0]         color_in;
  logic [cns_pkg::COLOR_W-1:0]         color_c;
  logic [cns_pkg::COLOR_W-1:0]         color_d;
  logic                                lo_next;
  logic [cns_pkg::T_W-1:0]             t_next;

  // operands
  logic signed [cns_pkg::SAMPLE_W-1:0] wp;
  logic signed [cns_pkg::STATE_W-1:0]  stage_rd;
  logic signed [cns_pkg::STATE_W-1:0]  sum_sat;
  logic signed [cns_pkg::STATE_W-1:0]  op_a;
  logic signed [cns_pkg::COEF_W-1:0]   op_b;

  // post stage
  logic signed [cns_pkg::PROD_W-1:0]   r7;
  logic signed [cns_pkg::PROD_W-1:0]   r9;
  logic signed [cns_pkg::PROD_W-1:0]   r16;
  logic signed [cns_pkg::PROD_W-1:0]   r25;
  logic signed [cns_pkg::PROD_W-1:0]   stg_sum;
  logic signed [cns_pkg::STATE_W-1:0]  stg_sat;
  logic signed [cns_pkg::STATE_W-1:0]  st6_sat;
  logic signed [cns_pkg::SAMPLE_W-1:0] pink_next;
  logic signed [cns_pkg::SAMPLE_W-1:0] bout_next;
  logic signed [cns_pkg::PROD_W-1:0]   mix_tot;
  logic signed [cns_pkg::PROD_W-1:0]   mix_r;
  logic signed [cns_pkg::SAMPLE_W-1:0] out_next;

  assign color_in = in_data[cns_pkg::COLOR_W-1:0];
  assign color_c  = (color_in > cns_pkg::COLOR_ONE) ? cns_pkg::COLOR_ONE : color_in;
  assign lo_next  = (color_c <= cns_pkg::COLOR_HALF);
  assign color_d  = color_c - cns_pkg::COLOR_HALF;
  assign t_next   = lo_next ? {color_c, 1'b0} : {color_d, 1'b0};

  // pink filter is driven by the second sample in the white/pink branch
  assign wp       = lo_reg ? w2_reg : w1_reg;
  assign stage_rd = (cmd.idx <= 3'd6) ? stage[cmd.idx] : '0;
  assign sum_sat  = cns_pkg::sat_state(cns_pkg::PROD_W'(sum));

  always_comb begin
    case (cmd.a_sel)
      cns_pkg::A_STAGE: op_a = stage_rd;
      cns_pkg::A_BROWN: op_a = brown;
      cns_pkg::A_SUM:   op_a = sum_sat;
      cns_pkg::A_WP:    op_a = cns_pkg::STATE_W'(wp);
      cns_pkg::A_WB:    op_a = cns_pkg::STATE_W'(w2_reg);
      cns_pkg::A_MIXA:  op_a = lo_reg ? cns_pkg::STATE_W'(w1_reg) : cns_pkg::STATE_W'(pk);
      cns_pkg::A_MIXB:  op_a = lo_reg ? cns_pkg::STATE_W'(pk) : cns_pkg::STATE_W'(br);
      default:          op_a = '0;
    endcase
  end

  always_comb begin
    case (cmd.b_sel)
      cns_pkg::B_COEF: op_b = cns_pkg::coef_value(cmd.coef);
      cns_pkg::B_T:    op_b = $signed(cns_pkg::COEF_W'(t_reg));
      cns_pkg::B_TINV: op_b = $signed(cns_pkg::COEF_W'(cns_pkg::T_ONE - t_reg));
      default:         op_b = '0;
    endcase
  end

  assign r7        = cns_pkg::rnd(prod, 7);
  assign r9        = cns_pkg::rnd(prod, 9);
  assign r16       = cns_pkg::rnd(prod, 16);
  assign r25       = cns_pkg::rnd(prod, 25);
  assign stg_sum   = cns_pkg::PROD_W'(acc) + r7;
  assign stg_sat   = cns_pkg::sat_state(stg_sum);
  assign st6_sat   = cns_pkg::sat_state(r7);
  assign pink_next = cns_pkg::sat_sample(r25);
  assign bout_next = cns_pkg::sat_sample(r9);
  assign mix_tot   = macc + prod;
  assign mix_r     = cns_pkg::rnd(mix_tot, 15);
  assign out_next  = cns_pkg::sat_sample(mix_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cns_pkg::PINK_N; i++) begin
        stage[i] <= '0;
      end
      brown     <= '0;
      post_q    <= cns_pkg::P_NONE;
      out_valid <= 1'b0;
    end else begin
      post_q <= cmd.post;
      if (post_q == cns_pkg::P_MIX_FIN) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (post_q)
        cns_pkg::P_STG: stage[idx_q] <= stg_sat;
        cns_pkg::P_ST6: stage[cns_pkg::PINK_N-1] <= st6_sat;
        cns_pkg::P_BRN: brown <= stg_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_reg  <= t_next;
      lo_reg <= lo_next;
      w1_reg <= in_data[cns_pkg::COLOR_W +: cns_pkg::SAMPLE_W];
      w2_reg <= in_data[cns_pkg::COLOR_W + cns_pkg::SAMPLE_W +: cns_pkg::SAMPLE_W];
    end
    prod  <= cns_pkg::PROD_W'(op_a) * cns_pkg::PROD_W'(op_b);
    idx_q <= cmd.idx;
    case (post_q)
      cns_pkg::P_ACC16:   acc <= r16[cns_pkg::ACC_W-1:0];
      cns_pkg::P_STG:     sum <= sum + cns_pkg::ACC_W'(stg_sat);
      // old delay stage joins the sum before it is overwritten
      cns_pkg::P_SUM_LD:  sum <= r7[cns_pkg::ACC_W-1:0] +
                                 cns_pkg::ACC_W'(stage[cns_pkg::PINK_N-1]);
      cns_pkg::P_PINK:    pk <= pink_next;
      cns_pkg::P_BOUT:    br <= bout_next;
      cns_pkg::P_MIX_LD:  macc <= prod;
      cns_pkg::P_MIX_FIN: out_data <= out_next;
      default: ;
    endcase
  end

  assign stat.lo       = lo_reg;
  assign stat.out_full = out_valid && !out_ready;

endmodule
`default_nettype wire

/* rtl/core/cns_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cns_checker: port-level checks for the noise shaper core
// Watches the stream handshakes and the item sequencing seen at the ports.
// ----------------------------------------------------------------------------
module cns_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [cns_pkg::SAMPLE_W-1:0]  m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // an accepted item keeps the core busy for the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted back to back");

  // a new result only comes out of a running item
  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready, 2))
    else $error("result appeared without item in progress");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind colored_noise_shaper_core cns_checker u_cns_checker (.*);
`default_nettype wire
